// ===== rtl/core/vca_pkg.sv =====
// Package for the voice channel allocator: field widths, command and status
// codes, and the structs passed between the front and back parts.
// No dependencies.
package vca_pkg;

  // Default table size and fixed field widths.
  localparam int CHANNELS_DEF = 32;
  localparam int ENT_W        = 10;
  localparam int SUB_W        = 3;
  localparam int ECH_W        = 4;
  localparam int NOW_W        = 31;
  localparam int LEN_W        = 24;
  localparam int REL_W        = 5;
  localparam int TIME_W       = 32;
  localparam int IDX_OUT_W    = 5;

  // Depth of the command queue and of the result queue.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TIME_W-1:0] LIFE_BOUND   = 32'h7fff_ffff;
  localparam logic [ENT_W-1:0]  PLAYER_RESET = 10'd1;

  // Command field codes.
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_GRANT = 2'd0,
    ST_NONE  = 2'd1,
    ST_NEG   = 2'd2,
    ST_FREED = 2'd3
  } status_e;

  // Operation class decided by the front part.
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_CLEAR,
    OP_NEG,
    OP_UNUSED
  } op_kind_e;

  // States of the back part sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WRITE
  } back_state_e;

  // Classified operation held in the command queue.
  typedef struct packed {
    op_kind_e           kind;
    logic [ENT_W-1:0]   entity;
    logic [SUB_W-1:0]   sub;
    logic [NOW_W-1:0]   now;
    logic [LEN_W-1:0]   len;
    logic [REL_W-1:0]   rel;
    logic               rel_ok;
  } op_t;

  // Handshake between the command queue and the back part.
  typedef struct packed {
    logic valid;
    op_t  op;
  } op_chan_t;

  // One stored channel entry.
  typedef struct packed {
    logic [ENT_W-1:0]  owner;
    logic [SUB_W-1:0]  sub;
    logic [TIME_W-1:0] end_time;
  } entry_t;

  // One result item.
  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] chan;
    logic                 ovr;
  } res_t;

endpackage

// ===== rtl/core/voice_channel_allocator.sv =====
// Top level of the voice channel allocator: player-entity register, command
// front part and table back part. Depends on vca_pkg, vca_front and vca_back.
//
// Command items enter a two-deep command queue and results leave through a
// two-deep result queue, so both sides can stall on their own. Release,
// clear-all, unused commands and negative sub-channel requests are handled in
// the idle state of the back part. An allocate goes through a start, one table
// memory read per channel on its single read port, evaluation of the last
// registered read data and a write-back that waits for room in the result
// queue; a same-source override ends the scan early. There is no
// clearing pass after reset: busy marks in flip-flops free the table at once.
module voice_channel_allocator import vca_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ENT_W-1:0]        cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd_i,
  input  logic [ENT_W-1:0]        entity_i,
  input  logic signed [ECH_W-1:0] entity_channel_i,
  input  logic [NOW_W-1:0]        now_time_i,
  input  logic [LEN_W-1:0]        sound_length_i,
  input  logic [REL_W-1:0]        release_index_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status_o,
  output logic [IDX_OUT_W-1:0]    channel_index_o,
  output logic                    overrode_same_source_o
);

  logic [ENT_W-1:0] player_q;
  op_chan_t         head;
  logic             head_pop;

  // Player entity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_q <= PLAYER_RESET;
    end else if (cfg_we_i) begin
      player_q <= cfg_data_i;
    end
  end

  // Command intake and classification.
  vca_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .cmd_i            (cmd_i),
    .entity_i         (entity_i),
    .entity_channel_i (entity_channel_i),
    .now_time_i       (now_time_i),
    .sound_length_i   (sound_length_i),
    .release_index_i  (release_index_i),
    .head_o           (head),
    .head_pop_i       (head_pop)
  );

  // Channel table and allocation scan.
  vca_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .player_i               (player_q),
    .head_i                 (head),
    .head_pop_o             (head_pop),
    .empty                  (empty),
    .pop                    (pop),
    .status_o               (status_o),
    .channel_index_o        (channel_index_o),
    .overrode_same_source_o (overrode_same_source_o)
  );

endmodule

// ===== rtl/core/vca_front.sv =====
// Front part of the voice channel allocator: accepts command items, classifies
// them and holds them in a short command queue for the back part.
// Depends on vca_pkg.
module vca_front import vca_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd_i,
  input  logic [ENT_W-1:0]        entity_i,
  input  logic signed [ECH_W-1:0] entity_channel_i,
  input  logic [NOW_W-1:0]        now_time_i,
  input  logic [LEN_W-1:0]        sound_length_i,
  input  logic [REL_W-1:0]        release_index_i,
  output op_chan_t                head_o,
  input  logic                    head_pop_i
);

  op_t               q_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  op_t               op_new;
  logic              do_push;
  logic              do_pop;

  // Classify the incoming item.
  always_comb begin
    op_new        = '0;
    op_new.entity = entity_i;
    op_new.sub    = entity_channel_i[SUB_W-1:0];
    op_new.now    = now_time_i;
    op_new.len    = sound_length_i;
    op_new.rel    = release_index_i;
    op_new.rel_ok = (32'(release_index_i) < CHANNELS);
    case (cmd_e'(cmd_i))
      CMD_ALLOC: begin
        op_new.kind = entity_channel_i[ECH_W-1] ? OP_NEG : OP_ALLOC;
      end
      CMD_RELEASE: op_new.kind = OP_RELEASE;
      CMD_CLEAR:   op_new.kind = OP_CLEAR;
      default:     op_new.kind = OP_UNUSED;
    endcase
  end

  // Queue pointers and fill count.
  assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = head_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_ptr_q] <= op_new;
    end
  end

  // Oldest queued operation.
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = q_q[rd_ptr_q];

endmodule

// ===== rtl/core/vca_back.sv =====
// Back part of the voice channel allocator: owns the channel table, runs the
// allocate scan one channel per cycle and queues the result items.
// Depends on vca_pkg.
module vca_back import vca_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ENT_W-1:0]     player_i,
  input  op_chan_t             head_i,
  output logic                 head_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status_o,
  output logic [IDX_OUT_W-1:0] channel_index_o,
  output logic                 overrode_same_source_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CHANNELS - 1);

  back_state_e       state_q, state_d;
  op_t               cur_q;
  entry_t            mem [CHANNELS];
  entry_t            rdata_q;
  entry_t            wdata;
  logic [CHANNELS-1:0] valid_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  ridx_q;
  logic [IDX_W-1:0]  win_q;
  logic [IDX_W-1:0]  rel_idx;
  logic              issued_all_q;
  logic              rtag_q;
  logic              rvalid_q;
  logic [TIME_W-1:0] best_q;
  logic              found_q;
  logic              ovr_q;
  logic              issue_en;
  logic              eval_en;
  logic              start;
  logic              scan_done;
  logic [ENT_W-1:0]  e_owner;
  logic [SUB_W-1:0]  e_sub;
  logic [TIME_W-1:0] e_end;
  logic [TIME_W-1:0] life;
  logic              ovr_hit;
  logic              prot;
  logic              better;
  logic              mem_we;
  logic              res_push;
  res_t              res_in;
  logic [IDX_W+IDX_OUT_W-1:0] win_ext;

  res_t              res_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] res_wr_q;
  logic [QPTR_W-1:0] res_rd_q;
  logic [QCNT_W-1:0] res_cnt_q;
  logic              res_full;
  logic              res_pop;

  // Scan control.
  assign start    = head_pop_o && (head_i.op.kind == OP_ALLOC);
  assign issue_en = (state_q == BK_SCAN) && !issued_all_q;
  assign eval_en  = (state_q == BK_SCAN) && rtag_q;

  // Evaluate the entry read in the previous cycle; a free entry reads as zero.
  always_comb begin
    e_owner = rvalid_q ? rdata_q.owner : '0;
    e_sub   = rvalid_q ? rdata_q.sub : '0;
    e_end   = rvalid_q ? rdata_q.end_time : '0;
    life    = e_end - {1'b0, cur_q.now};
    ovr_hit = (cur_q.sub != '0) && (e_owner == cur_q.entity) && (e_sub == cur_q.sub);
    prot    = rvalid_q && (e_owner == player_i) && (cur_q.entity != player_i);
    better  = $signed(life) < $signed(best_q);
  end

  assign scan_done = eval_en && (ovr_hit || (ridx_q == LAST));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (start) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_d = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (!res_full) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer: command pop, table write and result push.
  assign win_ext = {{IDX_OUT_W{1'b0}}, win_q};

  always_comb begin
    head_pop_o = 1'b0;
    mem_we     = 1'b0;
    res_push   = 1'b0;
    res_in     = '{status: ST_NONE, chan: '0, ovr: 1'b0};
    case (state_q)
      BK_IDLE: begin
        if (head_i.valid && ((head_i.op.kind == OP_ALLOC) || !res_full)) begin
          head_pop_o = 1'b1;
          case (head_i.op.kind)
            OP_ALLOC: res_push = 1'b0;
            OP_RELEASE, OP_CLEAR: begin
              res_push      = 1'b1;
              res_in.status = ST_FREED;
            end
            OP_NEG: begin
              res_push      = 1'b1;
              res_in.status = ST_NEG;
            end
            default: begin
              res_push      = 1'b1;
              res_in.status = ST_NONE;
            end
          endcase
        end
      end
      BK_WRITE: begin
        if (!res_full) begin
          res_push = 1'b1;
          mem_we   = found_q;
          if (found_q) begin
            res_in.status = ST_GRANT;
            res_in.chan   = win_ext[IDX_OUT_W-1:0];
            res_in.ovr    = ovr_q;
          end
        end
      end
      default: begin
        head_pop_o = 1'b0;
      end
    endcase
  end

  // Sequencer, scan pipeline and best-candidate registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      cnt_q        <= '0;
      issued_all_q <= 1'b0;
      rtag_q       <= 1'b0;
      rvalid_q     <= 1'b0;
      ridx_q       <= '0;
      best_q       <= LIFE_BOUND;
      win_q        <= '0;
      found_q      <= 1'b0;
      ovr_q        <= 1'b0;
    end else begin
      state_q  <= state_d;
      rtag_q   <= issue_en;
      rvalid_q <= valid_q[cnt_q];
      ridx_q   <= cnt_q;
      if (start) begin
        cnt_q        <= '0;
        issued_all_q <= 1'b0;
        best_q       <= LIFE_BOUND;
        found_q      <= 1'b0;
        ovr_q        <= 1'b0;
      end else begin
        if (issue_en) begin
          if (cnt_q == LAST) begin
            issued_all_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        if (eval_en) begin
          if (ovr_hit) begin
            win_q   <= ridx_q;
            found_q <= 1'b1;
            ovr_q   <= 1'b1;
          end else if (!prot && better) begin
            best_q  <= life;
            win_q   <= ridx_q;
            found_q <= 1'b1;
          end
        end
      end
    end
  end

  // Latched allocate request.
  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= head_i.op;
    end
  end

  // Busy marks: clear-all, release of one channel and grant.
  assign rel_idx = IDX_W'(head_i.op.rel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (head_pop_o && (head_i.op.kind == OP_CLEAR)) begin
      valid_q <= '0;
    end else if (head_pop_o && (head_i.op.kind == OP_RELEASE) && head_i.op.rel_ok) begin
      valid_q[rel_idx] <= 1'b0;
    end else if (mem_we) begin
      valid_q[win_q] <= 1'b1;
    end
  end

  // Channel table memory: one write port, one registered read port.
  always_comb begin
    wdata.owner    = cur_q.entity;
    wdata.sub      = cur_q.sub;
    wdata.end_time = {1'b0, cur_q.now} + {{(TIME_W-LEN_W){1'b0}}, cur_q.len};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[win_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rdata_q <= mem[cnt_q];
    end
  end

  // Result queue.
  assign res_full = (res_cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (res_cnt_q == '0);
  assign res_pop  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_in;
    end
  end

  assign status_o               = res_q[res_rd_q].status;
  assign channel_index_o        = res_q[res_rd_q].chan;
  assign overrode_same_source_o = res_q[res_rd_q].ovr;

  // A granted channel is marked busy right after the grant.
  a_grant_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_in.status == ST_GRANT)) |=> valid_q[$past(win_q)])
    else $error("granted channel not marked busy");

  // A clear-all leaves every channel free.
  a_clear_frees_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_pop_o && (head_i.op.kind == OP_CLEAR)) |=> (valid_q == '0))
    else $error("clear-all left a busy channel");

  // An override always comes with a winner.
  a_ovr_has_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovr_q |-> found_q)
    else $error("override flagged without a winner");

  // No table read is issued during write-back.
  a_no_read_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_WRITE) |-> !issue_en)
    else $error("table read issued during write-back");

endmodule

// ===== sim/voice_channel_allocator_test.sv =====
// Self-checking testbench for the voice channel allocator top level.
// Depends on vca_pkg and voice_channel_allocator; keeps its own model of the
// channel table and checks every result item against it in order.
module voice_channel_allocator_test import vca_pkg::*;;

  localparam int NCH         = CHANNELS_DEF;
  localparam int PERIOD      = 10;
  localparam int RESET_CYC   = 11;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE_CYC  = 60;

  // One command item as offered to the block.
  typedef struct packed {
    cmd_e             cmd;
    logic [ENT_W-1:0] entity;
    logic [ECH_W-1:0] ech;
    logic [NOW_W-1:0] now;
    logic [LEN_W-1:0] len;
    logic [REL_W-1:0] rel;
  } voice_req_t;

  // One row of the directed table; the result is typed in where obvious.
  typedef struct packed {
    voice_req_t rq;
    logic       fixed_exp;
    res_t       want;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [ENT_W-1:0]        cfg_data_i;
  logic                    push;
  logic                    full;
  logic [1:0]              cmd_i;
  logic [ENT_W-1:0]        entity_i;
  logic signed [ECH_W-1:0] entity_channel_i;
  logic [NOW_W-1:0]        now_time_i;
  logic [LEN_W-1:0]        sound_length_i;
  logic [REL_W-1:0]        release_index_i;
  logic                    empty;
  logic                    pop;
  logic [1:0]              status_o;
  logic [IDX_OUT_W-1:0]    channel_index_o;
  logic                    overrode_same_source_o;

  // Model of the channel table and the player register.
  logic              voice_busy  [NCH];
  logic [ENT_W-1:0]  voice_owner [NCH];
  logic [SUB_W-1:0]  voice_sub   [NCH];
  logic [TIME_W-1:0] voice_end   [NCH];
  logic [ENT_W-1:0]  player_ent;

  res_t             grant_q[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  logic             idle_on;
  logic             hold_req;
  logic [NOW_W-1:0] tick;

  voice_channel_allocator DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_data_i             (cfg_data_i),
    .push                   (push),
    .full                   (full),
    .cmd_i                  (cmd_i),
    .entity_i               (entity_i),
    .entity_channel_i       (entity_channel_i),
    .now_time_i             (now_time_i),
    .sound_length_i         (sound_length_i),
    .release_index_i        (release_index_i),
    .empty                  (empty),
    .pop                    (pop),
    .status_o               (status_o),
    .channel_index_o        (channel_index_o),
    .overrode_same_source_o (overrode_same_source_o)
  );

  // Free-running clock.
  always #(PERIOD / 2) clk_i = ~clk_i;

  // Free one channel in the model.
  function automatic void free_voice(int i);
    voice_busy[i]  = 1'b0;
    voice_owner[i] = '0;
    voice_sub[i]   = '0;
    voice_end[i]   = '0;
  endfunction

  // Apply one command to the model and return the result it should give.
  function automatic res_t predict_grant(voice_req_t rq);
    res_t   r;
    longint best;
    longint life;
    int     winner;
    logic   ovr;
    r.status = ST_NONE;
    r.chan   = '0;
    r.ovr    = 1'b0;
    case (rq.cmd)
      CMD_RELEASE: begin
        if (int'(rq.rel) < NCH) free_voice(int'(rq.rel));
        r.status = ST_FREED;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCH; i++) free_voice(i);
        r.status = ST_FREED;
      end
      CMD_ALLOC: begin
        if ($signed(rq.ech) < 0) begin
          r.status = ST_NEG;
        end else begin
          best   = 64'sh7fff_ffff;
          winner = -1;
          ovr    = 1'b0;
          for (int i = 0; i < NCH; i++) begin
            // Same entity and same non-zero sub-channel takes the voice at once.
            if (rq.ech != '0 && voice_owner[i] == rq.entity &&
                voice_sub[i] == rq.ech[SUB_W-1:0]) begin
              winner = i;
              ovr    = 1'b1;
              break;
            end
            // Busy player voices are protected from other requesters.
            if (!(voice_busy[i] && voice_owner[i] == player_ent &&
                  rq.entity != player_ent)) begin
              life = longint'($signed(voice_end[i] - {1'b0, rq.now}));
              if (life < best) begin
                best   = life;
                winner = i;
              end
            end
          end
          if (winner >= 0) begin
            voice_busy[winner]  = 1'b1;
            voice_owner[winner] = rq.entity;
            voice_sub[winner]   = rq.ech[SUB_W-1:0];
            voice_end[winner]   = {1'b0, rq.now} + TIME_W'(rq.len);
            r.status = ST_GRANT;
            r.chan   = IDX_OUT_W'(winner);
            r.ovr    = ovr;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // A command with every field random.
  function automatic voice_req_t rand_req();
    voice_req_t r;
    r.cmd    = cmd_e'($urandom_range(0, 3));
    r.entity = ENT_W'($urandom);
    r.ech    = ECH_W'($urandom);
    r.now    = NOW_W'($urandom);
    r.len    = LEN_W'($urandom);
    r.rel    = REL_W'($urandom);
    return r;
  endfunction

  function automatic dir_row_t mk_row(cmd_e c, int ent, int ech, int now, int len,
                                      int rel, bit fixed_exp, status_e st, int chan,
                                      bit ovr);
    dir_row_t d;
    d.rq.cmd      = c;
    d.rq.entity   = ENT_W'(ent);
    d.rq.ech      = ECH_W'(ech);
    d.rq.now      = NOW_W'(now);
    d.rq.len      = LEN_W'(len);
    d.rq.rel      = REL_W'(rel);
    d.fixed_exp   = fixed_exp;
    d.want.status = st;
    d.want.chan   = IDX_OUT_W'(chan);
    d.want.ovr    = ovr;
    return d;
  endfunction

  // Offer one item, wait for it to be taken, then queue its expected result.
  task automatic offer_item(voice_req_t rq, logic fixed_exp, res_t want);
    res_t pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push             <= 1'b1;
    cmd_i            <= rq.cmd;
    entity_i         <= rq.entity;
    entity_channel_i <= rq.ech;
    now_time_i       <= rq.now;
    sound_length_i   <= rq.len;
    release_index_i  <= rq.rel;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pred = predict_grant(rq);
    grant_q.push_back(fixed_exp ? want : pred);
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic settle_results();
    push <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_player(logic [ENT_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    player_ent = value;
    cfg_we_i   <= 1'b0;
  endtask

  // Random traffic: mostly allocations over a small set of entities, with
  // sequences that fill the whole table, plus releases, clears and noise.
  task automatic run_traffic(int count);
    int         sent;
    int         pick;
    int         fill;
    voice_req_t rq;
    res_t       none_res;
    sent     = 0;
    none_res = '0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      rq   = rand_req();
      if (pick < 4) begin
        // Fill every channel with player voices, then request as others.
        rq.cmd = CMD_CLEAR;
        offer_item(rq, 1'b0, none_res);
        sent++;
        fill = NCH + $urandom_range(0, 3);
        for (int k = 0; k < fill; k++) begin
          rq        = rand_req();
          rq.cmd    = CMD_ALLOC;
          rq.entity = player_ent;
          rq.ech    = '0;
          rq.now    = tick;
          rq.len    = LEN_W'($urandom_range(1, 5000));
          offer_item(rq, 1'b0, none_res);
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          rq        = rand_req();
          rq.cmd    = CMD_ALLOC;
          rq.entity = player_ent + ENT_W'($urandom_range(1, 1023));
          rq.ech    = ECH_W'($urandom_range(0, 7));
          rq.now    = tick;
          offer_item(rq, 1'b0, none_res);
          sent++;
        end
      end else if (pick < 8) begin
        // Fill every channel with the largest remaining life, then ask again.
        rq.cmd = CMD_CLEAR;
        offer_item(rq, 1'b0, none_res);
        sent++;
        for (int k = 0; k < NCH; k++) begin
          rq     = rand_req();
          rq.cmd = CMD_ALLOC;
          rq.ech = '0;
          rq.now = NOW_W'(32'h7fff_0000);
          rq.len = LEN_W'(32'h0000_ffff);
          offer_item(rq, 1'b0, none_res);
          sent++;
        end
        rq     = rand_req();
        rq.cmd = CMD_ALLOC;
        rq.ech = '0;
        rq.now = '0;
        offer_item(rq, 1'b0, none_res);
        sent++;
      end else begin
        if (pick < 65) begin
          rq.cmd = CMD_ALLOC;
          case ($urandom_range(0, 5))
            0:       rq.entity = player_ent;
            1:       rq.entity = ENT_W'(1);
            2:       rq.entity = ENT_W'(2);
            3:       rq.entity = ENT_W'(3);
            4:       rq.entity = ENT_W'(1023);
            default: ;
          endcase
          if ($urandom_range(0, 9) == 0) rq.ech = ECH_W'($urandom_range(8, 15));
          else rq.ech = ECH_W'($urandom_range(0, 7));
          tick = tick + NOW_W'($urandom_range(0, 3000));
          if ($urandom_range(0, 19) != 0) rq.now = tick;
          if ($urandom_range(0, 9) != 0) rq.len = LEN_W'($urandom_range(0, 20000));
        end else if (pick < 85) begin
          rq.cmd = CMD_RELEASE;
        end else if (pick < 89) begin
          rq.cmd = CMD_CLEAR;
        end else if (pick < 93) begin
          rq.cmd = CMD_UNUSED;
        end
        offer_item(rq, 1'b0, none_res);
        sent++;
      end
    end
  endtask

  // Result side: random pop bursts, plus one long hold-off on request.
  initial begin : result_drain
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.status = status_e'(status_o);
      got.chan   = channel_index_o;
      got.ovr    = overrode_same_source_o;
      if (grant_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result item: status %0d chan %0d ovr %0d",
                   got.status, got.chan, got.ovr);
      end else begin
        want = grant_q.pop_front();
        if (got.status !== want.status || got.chan !== want.chan ||
            got.ovr !== want.ovr) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected status %0d chan %0d ovr %0d, got %0d %0d %0d",
                     want.status, want.chan, want.ovr, got.status, got.chan, got.ovr);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_data_i       <= '0;
    push             <= 1'b0;
    cmd_i            <= '0;
    entity_i         <= '0;
    entity_channel_i <= '0;
    now_time_i       <= '0;
    sound_length_i   <= '0;
    release_index_i  <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    tick     = '0;
    player_ent = PLAYER_RESET;
    for (int i = 0; i < NCH; i++) free_voice(i);

    // Directed table, run with the player register at its reset value.
    rows.push_back(mk_row(CMD_ALLOC, 5, 1, 0, 100, 0, 1, ST_GRANT, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 5, 1, 10, 50, 0, 1, ST_GRANT, 0, 1));
    rows.push_back(mk_row(CMD_ALLOC, 5, 0, 10, 0, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 5, -8, 10, 0, 0, 1, ST_NEG, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 5, -1, 10, 0, 0, 1, ST_NEG, 0, 0));
    rows.push_back(mk_row(CMD_UNUSED, 0, 0, 0, 0, 0, 1, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 1, 3, 20, 1000, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 2, 3, 20, 1000, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 1, 3, 30, 1000, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_RELEASE, 0, 0, 0, 0, 0, 1, ST_FREED, 0, 0));
    rows.push_back(mk_row(CMD_RELEASE, 0, 0, 0, 0, 31, 1, ST_FREED, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 1023, 7, 32'h7fff_ffff, 32'hff_ffff, 0, 0,
                          ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 0, 7, 0, 0, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 1023, 7, 32'h7fff_ffff, 0, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 0, 0, 32'h4000_0000, 32'hff_ffff, 0, 0,
                          ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, ST_FREED, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 0, 0, 0, 0, 0, 1, ST_GRANT, 0, 0));
    rows.push_back(mk_row(CMD_ALLOC, 0, 0, 0, 0, 0, 0, ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_UNUSED, 1023, -1, 32'h7fff_ffff, 32'hff_ffff, 31, 1,
                          ST_NONE, 0, 0));
    rows.push_back(mk_row(CMD_RELEASE, 0, 0, 0, 0, 17, 1, ST_FREED, 0, 0));
    rows.push_back(mk_row(CMD_CLEAR, 1023, 7, 0, 0, 0, 1, ST_FREED, 0, 0));

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < rows.size(); k++)
      offer_item(rows[k].rq, rows[k].fixed_exp, rows[k].want);

    // Random phases, each under its own player setting; the first one
    // starts with a long hold-off on the result side.
    settle_results();
    write_player('0);
    hold_req = 1'b1;
    run_traffic(330);

    settle_results();
    write_player('1);
    run_traffic(330);

    settle_results();
    write_player(ENT_W'($urandom));
    run_traffic(330);

    settle_results();
    write_player(ENT_W'(2));
    run_traffic(330);

    // Last phase runs at full rate on both sides.
    settle_results();
    write_player(PLAYER_RESET);
    idle_on = 1'b0;
    run_traffic(310);

    settle_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0 && grant_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/vca_pkg.sv
rtl/core/vca_front.sv
rtl/core/vca_back.sv
rtl/core/voice_channel_allocator.sv
sim/voice_channel_allocator_test.sv
